### rtl/core/assert_macros.svh
// assertion macros used by the rtl top level of the free block table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked at every clock edge while out of reset
`define SBFT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("free block table: property violated");
// property checked at every clock edge, reset included
`define SBFT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("free block table: property violated");
`else
`define SBFT_ASSERT(lbl, clk, rstn, prop)
`define SBFT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/sbft_pkg.sv
// types and codes shared by the free block table modules
`default_nettype none
package sbft_pkg;

    // width of the address fields on the stream ports
    localparam int unsigned FIELD_W = 32;

    // command codes
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // status codes of a result word
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXTRACTED = 2'd2;
    localparam logic [1:0] ST_NO_FIT    = 2'd3;

    // one command word
    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] block_start;
        logic [FIELD_W-1:0] block_end;
        logic [FIELD_W-1:0] request_size;
    } cmd_t;

    // one result word
    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] out_start;
        logic [FIELD_W-1:0] out_end;
    } res_t;

endpackage
`default_nettype wire

### rtl/core/sbft_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module sbft_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/sbft_engine.sv
// sorted table engine: walks the entry ram from the top, shifting as it goes
`default_nettype none
module sbft_engine #(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned ADDR_BITS = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire sbft_pkg::cmd_t             cmd,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output sbft_pkg::res_t                  res,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned ENT_W = 2 * ADDR_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 first_reg, first_next;
    logic                 op_reg, op_next;
    logic [ADDR_BITS-1:0] new_start_reg, new_start_next;
    logic [ADDR_BITS-1:0] new_end_reg, new_end_next;
    logic [ADDR_BITS-1:0] key_reg, key_next;
    logic [ENT_W-1:0]     carry_reg, carry_next;
    sbft_pkg::res_t       res_reg, res_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENT_W-1:0]     wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENT_W-1:0]     rd_data;

    logic [ADDR_BITS-1:0] in_start;
    logic [ADDR_BITS-1:0] in_end;
    logic [ADDR_BITS-1:0] in_req;
    logic [ADDR_BITS-1:0] e_start;
    logic [ADDR_BITS-1:0] e_end;
    logic [ADDR_BITS-1:0] e_size;
    logic [ENT_W-1:0]     new_entry;

    // entry store, end address in the upper half
    sbft_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // incoming fields at table width
    assign in_start  = ADDR_BITS'(cmd.block_start);
    assign in_end    = ADDR_BITS'(cmd.block_end);
    assign in_req    = ADDR_BITS'(cmd.request_size);

    // entry read back this cycle and its size
    assign e_start   = rd_data[ADDR_BITS-1:0];
    assign e_end     = rd_data[ENT_W-1:ADDR_BITS];
    assign e_size    = e_end - e_start;
    assign new_entry = {new_end_reg, new_start_reg};

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign count     = count_reg;

    // sequencer: one entry read and at most one written per cycle
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        first_next     = first_reg;
        op_next        = op_reg;
        new_start_next = new_start_reg;
        new_end_next   = new_end_reg;
        key_next       = key_reg;
        carry_next     = carry_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg + IDX_W'(1);
        wr_data        = new_entry;
        rd_en          = 1'b0;
        rd_addr        = idx_reg - IDX_W'(1);

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    op_next        = cmd.cmd;
                    new_start_next = in_start;
                    new_end_next   = in_end;
                    first_next     = 1'b1;
                    idx_next       = IDX_W'(count_reg - CNT_W'(1));
                    rd_addr        = IDX_W'(count_reg - CNT_W'(1));
                    res_next       = '{status: sbft_pkg::ST_INSERTED,
                                       out_start: '0, out_end: '0};
                    if (cmd.cmd == sbft_pkg::CMD_INSERT) begin
                        key_next = in_end - in_start;
                        if (count_reg == CNT_W'(DEPTH)) begin
                            res_next.status = sbft_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end else if (count_reg == '0) begin
                            // empty table: store straight at the bottom
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = {in_end, in_start};
                            state_next = S_DONE;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = S_SCAN;
                        end
                    end else begin
                        key_next = in_req;
                        if (count_reg == '0) begin
                            res_next.status = sbft_pkg::ST_NO_FIT;
                            state_next      = S_DONE;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                if (op_reg == sbft_pkg::CMD_INSERT) begin
                    if (e_size > key_reg) begin
                        // larger entry moves up one place
                        wr_en   = 1'b1;
                        wr_data = rd_data;
                        if (idx_reg == '0) begin
                            state_next = S_PUT;
                        end else begin
                            rd_en    = 1'b1;
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end else begin
                        // new block lands above this entry
                        wr_en           = 1'b1;
                        res_next.status = sbft_pkg::ST_INSERTED;
                        state_next      = S_DONE;
                    end
                end else begin
                    if (e_size >= key_reg) begin
                        // fitting entries form the top run; shift the one above down
                        wr_en      = !first_reg;
                        wr_addr    = idx_reg;
                        wr_data    = carry_reg;
                        carry_next = rd_data;
                        first_next = 1'b0;
                        if (idx_reg == '0) begin
                            res_next   = '{status: sbft_pkg::ST_EXTRACTED,
                                           out_start: sbft_pkg::FIELD_W'(e_start),
                                           out_end: sbft_pkg::FIELD_W'(e_end)};
                            state_next = S_DONE;
                        end else begin
                            rd_en    = 1'b1;
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end else begin
                        if (first_reg) begin
                            res_next.status = sbft_pkg::ST_NO_FIT;
                        end else begin
                            res_next = '{status: sbft_pkg::ST_EXTRACTED,
                                out_start: sbft_pkg::FIELD_W'(carry_reg[ADDR_BITS-1:0]),
                                out_end: sbft_pkg::FIELD_W'(carry_reg[ENT_W-1:ADDR_BITS])};
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_PUT: begin
                // every entry moved up: new block goes to the bottom
                wr_en           = 1'b1;
                wr_addr         = '0;
                res_next.status = sbft_pkg::ST_INSERTED;
                state_next      = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    if (res_reg.status == sbft_pkg::ST_INSERTED) begin
                        count_next = count_reg + CNT_W'(1);
                    end else if (res_reg.status == sbft_pkg::ST_EXTRACTED) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            first_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        op_reg        <= op_next;
        new_start_reg <= new_start_next;
        new_end_reg   <= new_end_next;
        key_reg       <= key_next;
        carry_reg     <= carry_next;
        res_reg       <= res_next;
    end

endmodule
`default_nettype wire

### rtl/core/size_sorted_free_block_table.sv
// size sorted free block table (best fit free list), top level
//
// s_ channel takes one command word: tuser selects insert (0) or extract (1),
// tdata carries the block start, block end and requested size. m_ channel
// returns exactly one result word per command: tuser holds the status
// (inserted, dropped as full, extracted, no fit), tdata the extracted block
// or zeros. Entries sit in one ram, smallest size at the lowest address.
// A command walks the ram from the highest entry down, one entry a cycle
// (registered read, write back one place up or down), stopping
// at the insert point or below the best fit. At most the fill level of
// entries are visited (plus one step for an insert at the bottom), then the
// result goes through the output register to m_tvalid, and s_tready returns at
// the same time, so a new command is taken only once the last one is through. The m_ output register
// lets the next command be taken while a result waits; a further result
// waits inside the engine until m_tready frees the register, and s_tready
// stays low meanwhile. Reset (aresetn low, synchronous) empties the table
// and drops any result in flight; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module size_sorted_free_block_table #(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned ADDR_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // block_start, block_end, request_size
    input  wire logic [0:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // out_start, out_end
    output logic [1:0]       m_tuser    // status
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sbft_pkg::cmd_t     cmd;
    sbft_pkg::res_t     res;
    logic               res_valid;
    logic               res_ready;
    logic [CNT_W-1:0]   count;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [63:0]        m_tdata_reg, m_tdata_next;
    logic [1:0]         m_tuser_reg, m_tuser_next;
    logic               ins_done;
    logic               ext_done;
    logic               full_out;
    logic               plain_out;

    // unpack the command word
    assign cmd.cmd          = s_tuser[0];
    assign cmd.block_start  = s_tdata[31:0];
    assign cmd.block_end    = s_tdata[63:32];
    assign cmd.request_size = s_tdata[95:64];

    sbft_engine #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .count     (count)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            m_tdata_next  = {res.out_end, res.out_start};
            m_tuser_next  = res.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // result word kinds seen by the checks
    assign ins_done  = res_valid && res_ready && res.status == sbft_pkg::ST_INSERTED;
    assign ext_done  = res_valid && res_ready && res.status == sbft_pkg::ST_EXTRACTED;
    assign full_out  = res_valid && res.status == sbft_pkg::ST_FULL;
    assign plain_out = res_valid && res.status != sbft_pkg::ST_EXTRACTED;

    // checks on fill level and result contents
    `SBFT_ASSERT(a_count_bound, aclk, aresetn, count <= CNT_W'(DEPTH))
    `SBFT_ASSERT(a_insert_grows, aclk, aresetn, ins_done |=> count == $past(count) + CNT_W'(1))
    `SBFT_ASSERT(a_extract_shrinks, aclk, aresetn, ext_done |=> count == $past(count) - CNT_W'(1))
    `SBFT_ASSERT(a_full_only_full, aclk, aresetn, full_out |-> count == CNT_W'(DEPTH))
    `SBFT_ASSERT(a_zero_payload, aclk, aresetn, plain_out |-> res.out_start == '0 && res.out_end == '0)

endmodule
`default_nettype wire

### test/size_sorted_free_block_table_check.sv
// checker for the free block table: predicts every result word and compares it on arrival
`default_nettype none
module size_sorted_free_block_table_check #(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] s_tdata,   // block_start, block_end, request_size
    input  wire logic [0:0]  s_tuser,   // cmd
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,   // out_start, out_end
    input  wire logic [1:0]  m_tuser,   // status
    output int               error_count,
    output int               words_outstanding
);

    // own copy of the table, smallest block first
    logic [31:0] free_start [DEPTH];
    logic [31:0] free_end   [DEPTH];
    int          free_count;

    // result words still to come, oldest first
    sbft_pkg::res_t expected_results [$];
    sbft_pkg::res_t want;
    sbft_pkg::cmd_t taken;

    initial begin
        error_count       = 0;
        words_outstanding = 0;
        free_count        = 0;
    end

    // block size wraps at the address width
    function automatic logic [31:0] block_span(input logic [31:0] lo, input logic [31:0] hi);
        return hi - lo;
    endfunction

    // apply one command word to the table and give the result word it causes
    function automatic sbft_pkg::res_t apply_table_cmd(input sbft_pkg::cmd_t w);
        sbft_pkg::res_t r;
        int             pos;
        int             i;
        logic [31:0]    sz;
        r = '0;
        if (w.cmd == sbft_pkg::CMD_INSERT) begin
            sz = block_span(w.block_start, w.block_end);
            if (free_count >= DEPTH) begin
                r.status = sbft_pkg::ST_FULL;
            end else begin
                // after every entry of smaller or equal size
                pos = free_count;
                for (i = 0; i < free_count; i++) begin
                    if (pos == free_count && sz < block_span(free_start[i], free_end[i]))
                        pos = i;
                end
                for (i = free_count; i > pos; i--) begin
                    free_start[i] = free_start[i-1];
                    free_end[i]   = free_end[i-1];
                end
                free_start[pos] = w.block_start;
                free_end[pos]   = w.block_end;
                free_count++;
                r.status = sbft_pkg::ST_INSERTED;
            end
        end else begin
            // best fit is the first entry big enough
            pos = free_count;
            for (i = 0; i < free_count; i++) begin
                if (pos == free_count &&
                    block_span(free_start[i], free_end[i]) >= w.request_size)
                    pos = i;
            end
            if (pos == free_count) begin
                r.status = sbft_pkg::ST_NO_FIT;
            end else begin
                r.status    = sbft_pkg::ST_EXTRACTED;
                r.out_start = free_start[pos];
                r.out_end   = free_end[pos];
                for (i = pos; i + 1 < free_count; i++) begin
                    free_start[i] = free_start[i+1];
                    free_end[i]   = free_end[i+1];
                end
                free_count--;
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
            error_count++;
        end
    endtask

    // results first: a word accepted now cannot be the answer to a command taken now
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual status %0d %h",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", {30'd0, want.status}, {30'd0, m_tuser});
                    compare_field("out_start", want.out_start, m_tdata[31:0]);
                    compare_field("out_end", want.out_end, m_tdata[63:32]);
                end
            end
            if (s_tvalid && s_tready) begin
                taken.cmd          = s_tuser[0];
                taken.block_start  = s_tdata[31:0];
                taken.block_end    = s_tdata[63:32];
                taken.request_size = s_tdata[95:64];
                expected_results.push_back(apply_table_cmd(taken));
            end
        end
        words_outstanding = expected_results.size();
    end

endmodule
`default_nettype wire

### test/size_sorted_free_block_table_test.sv
// testbench top for the free block table: stimulus, back pressure and verdict
`default_nettype none
module size_sorted_free_block_table_test;

    localparam int TABLE_DEPTH = 16;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    int          error_count;
    int          outstanding;
    logic        steady    = 1'b0;
    int          ready_hold = 0;

    size_sorted_free_block_table #(
        .DEPTH     (TABLE_DEPTH),
        .ADDR_BITS (32)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    size_sorted_free_block_table_check #(
        .DEPTH (TABLE_DEPTH)
    ) u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .error_count       (error_count),
        .words_outstanding (outstanding)
    );

    always #10 aclk = ~aclk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // small sizes make equal sizes and near misses common
    function automatic logic [31:0] pick_size();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 4) return $urandom_range(0, 15);
        if (k < 7) return $urandom_range(0, 255);
        if (k < 9) return $urandom();
        return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endfunction

    function automatic logic [31:0] pick_request();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return 32'd0;
        if (k < 4) return $urandom_range(0, 20);
        if (k < 7) return $urandom_range(0, 300);
        if (k < 9) return $urandom();
        return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endfunction

    // receiver stalls
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // offer one command word, wait for it to be taken, then maybe idle
    task automatic put_word(input logic c, input logic [31:0] bs, input logic [31:0] be,
                            input logic [31:0] req);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {req, be, bs};
        do @(posedge aclk); while (!s_tready);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // hold off the sender until every result word is back
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    initial begin
        int          n;
        int          insert_pct;
        logic [31:0] base;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extreme blocks, wrapped block, zero and full requests
        put_word(sbft_pkg::CMD_EXTRACT, 32'd0, 32'd0, 32'd0);
        put_word(sbft_pkg::CMD_INSERT, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_word(sbft_pkg::CMD_INSERT, 32'd10, 32'd5, 32'd0);
        put_word(sbft_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        put_word(sbft_pkg::CMD_INSERT, 32'h1234_0000, 32'h1234_0000, 32'd0);
        put_word(sbft_pkg::CMD_INSERT, 32'h0000_1000, 32'h0000_1040, 32'd0);
        put_word(sbft_pkg::CMD_INSERT, 32'h8000_0000, 32'h8000_0040, 32'd0);
        put_word(sbft_pkg::CMD_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        put_word(sbft_pkg::CMD_EXTRACT, 32'd0, 32'd0, 32'hFFFF_FFFF);
        // fill to the top, repeating sizes, then one insert too many
        for (n = 0; n < 12; n++) begin
            base = $urandom();
            put_word(sbft_pkg::CMD_INSERT, base, base + (n % 4) * 3, 32'd0);
        end
        put_word(sbft_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        put_word(sbft_pkg::CMD_EXTRACT, 32'd0, 32'd0, 32'hFFFF_FFFF);
        wait_for_results();

        // random: phases that favour filling, draining or a balance
        insert_pct = 50;
        for (n = 0; n < 1950; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 80;
                    1: insert_pct = 25;
                    default: insert_pct = 50;
                endcase
                steady <= ($urandom_range(0, 3) == 0);
            end
            if (n % 400 == 200)
                wait_for_results();
            if ($urandom_range(0, 99) < insert_pct) begin
                base = $urandom();
                put_word(sbft_pkg::CMD_INSERT, base, base + pick_size(), $urandom());
            end else begin
                put_word(sbft_pkg::CMD_EXTRACT, $urandom(), $urandom(), pick_request());
            end
        end

        // drain and let any stray word show up
        wait_for_results();
        repeat (40) @(negedge aclk);
        if (error_count == 0) begin
            $display("size_sorted_free_block_table test passed");
        end else begin
            $display("size_sorted_free_block_table test failed");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #20000000;
        $display("size_sorted_free_block_table test failed");
        $finish;
    end

endmodule
`default_nettype wire
